### rtl/core/lfs_pkg.sv
// Shared constants and types for the looping frame store.
// Used by the slot memory, the position wrap unit and the top level.
package lfs_pkg;

  localparam int HANDLE_W      = 16;           // frame handle width
  localparam int SLOT_DW       = HANDLE_W + 1; // full flag plus handle
  localparam int POS_W         = 16;           // signed position width
  localparam int DUR_W         = 16;           // signed duration width
  localparam int LEN_W         = 9;            // loop_length register width
  localparam int LEN_CAP       = 511;          // largest value loop_length can hold
  localparam int MAX_SLOTS_DEF = 256;
  localparam int OP_W          = 3;
  localparam int CFG_IDX_W     = 1;
  localparam int OUT_SLOT_W    = 8;

  localparam logic [OP_W-1:0] OP_FRAME_IN  = 3'd0;
  localparam logic [OP_W-1:0] OP_PLAY      = 3'd1;
  localparam logic [OP_W-1:0] OP_SEEK      = 3'd2;
  localparam logic [OP_W-1:0] OP_SEEK_PLAY = 3'd3;
  localparam logic [OP_W-1:0] OP_RECORD    = 3'd4;
  localparam logic [OP_W-1:0] OP_STORE_ONE = 3'd5;
  localparam logic [OP_W-1:0] OP_STOP      = 3'd6;
  localparam logic [OP_W-1:0] OP_CLEAR     = 3'd7;

  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLE = 1'd1;

  localparam logic [LEN_W-1:0] LOOP_LENGTH_RST = 9'd256;

  // Start of one wrap: sign and magnitude of the value to reduce modulo the length.
  typedef struct packed {
    logic             start;
    logic             neg;
    logic [POS_W-1:0] mag;
  } lfs_wrap_req_t;

endpackage

### rtl/core/looping_frame_store.sv
// Looping frame store: a ring of frame-handle slots with a record head and a play head.
// A frame-in or stop request is handled in the idle state; a play request reads the slot
// memory, then loads the output register from the response state, which waits while the
// held result is not taken. Seek, record, store-one and seek-and-play requests go through
// the 16-step bit-serial remainder unit; a play whose head lies beyond a shortened loop
// goes through the same unit. After reset and after every clear request the block sweeps
// all min(MAX_SLOTS, 511) slots of the slot memory (256 at the default), one slot a cycle,
// and takes no request meanwhile; configuration writes are taken at any time. A played
// result waits in the output register while the next request is taken. Depends on
// lfs_pkg, lfs_slot_mem and lfs_wrap_unit.
module looping_frame_store
  import lfs_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Input requests.
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [47:0]          in_tdata,   // position, duration, frame_handle
  input  logic [OP_W-1:0]      in_tuser,   // opcode
  // Played slots.
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [23:0]          out_tdata,  // slot_index, played_handle
  output logic [0:0]           out_tuser,  // handle_valid
  // Configuration writes.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEN_W-1:0]     cfg_data
);

  localparam int DEPTH  = (MAX_SLOTS < LEN_CAP) ? MAX_SLOTS : LEN_CAP;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int SLOT_W = $clog2(DEPTH + 1);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_WRAP  = 2'd2;
  localparam logic [1:0] ST_RESP  = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [OP_W-1:0]       op_r, op_nxt;
  logic [DUR_W-1:0]      dur_r, dur_nxt;
  logic [LEN_W-1:0]      loop_length_r, loop_length_nxt;
  logic                  loop_enable_r, loop_enable_nxt;
  logic [SLOT_W-1:0]     play_slot_r, play_slot_nxt;
  logic                  past_end_r, past_end_nxt;
  logic [SLOT_W-1:0]     record_slot_r, record_slot_nxt;
  logic [DUR_W-1:0]      frames_left_r, frames_left_nxt;
  logic [IDX_W-1:0]      clr_cnt_r, clr_cnt_nxt;
  logic [OUT_SLOT_W-1:0] resp_slot_r, resp_slot_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [HANDLE_W-1:0]   out_handle_r, out_handle_nxt;
  logic                  out_hv_r, out_hv_nxt;

  logic [POS_W-1:0]      in_position;
  logic [DUR_W-1:0]      in_duration;
  logic [HANDLE_W-1:0]   in_handle;
  logic                  accept;
  logic [SLOT_W-1:0]     len;
  logic [SLOT_W-1:0]     rec_inc;
  logic [SLOT_W-1:0]     play_inc;

  logic                  play_go;
  logic [SLOT_W-1:0]     play_s;
  logic                  play_clear_pe;

  lfs_wrap_req_t         wrap_req;
  logic                  wrap_done;
  logic [SLOT_W-1:0]     wrap_res;

  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [SLOT_DW-1:0]    wr_data;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic [SLOT_DW-1:0]    rd_data;

  assign in_position = in_tdata[15:0];
  assign in_duration = in_tdata[31:16];
  assign in_handle   = in_tdata[47:32];
  assign in_tready   = (state_r == ST_IDLE);
  assign accept      = in_tvalid && in_tready;
  assign cfg_ready   = 1'b1;

  // Loop length clamped to 2..DEPTH.
  always_comb begin
    if (loop_length_r < LEN_W'(2)) begin
      len = SLOT_W'(2);
    end else if (loop_length_r > LEN_W'(DEPTH)) begin
      len = SLOT_W'(DEPTH);
    end else begin
      len = SLOT_W'(loop_length_r);
    end
  end

  assign rec_inc  = record_slot_r + 1'b1;
  assign play_inc = play_s + 1'b1;

  lfs_wrap_unit #(
    .SLOT_W (SLOT_W)
  ) u_wrap (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (wrap_req),
    .len    (len),
    .done   (wrap_done),
    .result (wrap_res)
  );

  lfs_slot_mem #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    dur_nxt         = dur_r;
    loop_length_nxt = loop_length_r;
    loop_enable_nxt = loop_enable_r;
    play_slot_nxt   = play_slot_r;
    past_end_nxt    = past_end_r;
    record_slot_nxt = record_slot_r;
    frames_left_nxt = frames_left_r;
    clr_cnt_nxt     = clr_cnt_r;
    resp_slot_nxt   = resp_slot_r;
    out_valid_nxt   = out_valid_r;
    out_slot_nxt    = out_slot_r;
    out_handle_nxt  = out_handle_r;
    out_hv_nxt      = out_hv_r;
    wrap_req        = '0;
    wr_en           = 1'b0;
    wr_addr         = clr_cnt_r;
    wr_data         = '0;
    rd_en           = 1'b0;
    rd_addr         = '0;
    play_go         = 1'b0;
    play_s          = play_slot_r;
    play_clear_pe   = 1'b0;

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LOOP_LENGTH: loop_length_nxt = cfg_data;
        CFG_LOOP_ENABLE: loop_enable_nxt = cfg_data[0];
        default: ;
      endcase
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        wr_en = 1'b1;
        if (clr_cnt_r == IDX_W'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          op_nxt  = in_tuser;
          dur_nxt = in_duration;
          unique case (in_tuser)
            OP_FRAME_IN: begin
              if (frames_left_r != '0) begin
                if (record_slot_r >= len) begin
                  frames_left_nxt = '0;
                end else begin
                  wr_en           = 1'b1;
                  wr_addr         = record_slot_r[IDX_W-1:0];
                  wr_data         = {1'b1, in_handle};
                  frames_left_nxt = frames_left_r - 1'b1;
                  record_slot_nxt = rec_inc;
                  if (rec_inc == len) begin
                    frames_left_nxt = '0;
                  end
                end
              end
            end
            OP_PLAY: begin
              if (loop_enable_r || !past_end_r) begin
                if (play_slot_r < len) begin
                  play_go = 1'b1;
                end else begin
                  // Head left beyond a shortened loop: reduce it first.
                  wrap_req.start = 1'b1;
                  wrap_req.neg   = 1'b0;
                  wrap_req.mag   = POS_W'(play_slot_r);
                  state_nxt      = ST_WRAP;
                end
              end
            end
            OP_SEEK, OP_SEEK_PLAY, OP_RECORD, OP_STORE_ONE: begin
              wrap_req.start = 1'b1;
              wrap_req.neg   = in_position[POS_W-1];
              wrap_req.mag   = in_position[POS_W-1] ? (~in_position + 1'b1) : in_position;
              state_nxt      = ST_WRAP;
            end
            OP_STOP: begin
              frames_left_nxt = '0;
            end
            OP_CLEAR: begin
              play_slot_nxt   = '0;
              past_end_nxt    = 1'b0;
              record_slot_nxt = '0;
              clr_cnt_nxt     = '0;
              state_nxt       = ST_CLEAR;
            end
            default: ;
          endcase
        end
      end
      ST_WRAP: begin
        if (wrap_done) begin
          state_nxt = ST_IDLE;
          case (op_r)
            OP_PLAY: begin
              play_go = 1'b1;
              play_s  = wrap_res;
            end
            OP_SEEK: begin
              play_slot_nxt = wrap_res;
              past_end_nxt  = 1'b0;
            end
            OP_SEEK_PLAY: begin
              play_go       = 1'b1;
              play_s        = wrap_res;
              play_clear_pe = 1'b1;
            end
            OP_RECORD: begin
              record_slot_nxt = wrap_res;
              if (dur_r[DUR_W-1] || (dur_r == '0)) begin
                frames_left_nxt = DUR_W'(len - wrap_res);
              end else begin
                frames_left_nxt = dur_r;
              end
            end
            OP_STORE_ONE: begin
              record_slot_nxt = wrap_res;
              frames_left_nxt = DUR_W'(1);
            end
            default: ;
          endcase
        end
      end
      ST_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_slot_nxt   = resp_slot_r;
          out_handle_nxt = rd_data[SLOT_DW-1] ? rd_data[HANDLE_W-1:0] : '0;
          out_hv_nxt     = rd_data[SLOT_DW-1];
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // Issue the slot read and advance the play head.
    if (play_go) begin
      rd_en         = 1'b1;
      rd_addr       = play_s[IDX_W-1:0];
      resp_slot_nxt = OUT_SLOT_W'(play_s);
      state_nxt     = ST_RESP;
      if (play_inc >= len) begin
        play_slot_nxt = '0;
        past_end_nxt  = 1'b1;
      end else begin
        play_slot_nxt = play_inc;
        past_end_nxt  = play_clear_pe ? 1'b0 : past_end_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      clr_cnt_r     <= '0;
      loop_length_r <= LOOP_LENGTH_RST;
      loop_enable_r <= 1'b1;
      play_slot_r   <= '0;
      past_end_r    <= 1'b0;
      record_slot_r <= '0;
      frames_left_r <= '0;
      out_valid_r   <= 1'b0;
      op_r          <= OP_FRAME_IN;
    end else begin
      state_r       <= state_nxt;
      clr_cnt_r     <= clr_cnt_nxt;
      loop_length_r <= loop_length_nxt;
      loop_enable_r <= loop_enable_nxt;
      play_slot_r   <= play_slot_nxt;
      past_end_r    <= past_end_nxt;
      record_slot_r <= record_slot_nxt;
      frames_left_r <= frames_left_nxt;
      out_valid_r   <= out_valid_nxt;
      op_r          <= op_nxt;
    end
    dur_r        <= dur_nxt;
    resp_slot_r  <= resp_slot_nxt;
    out_slot_r   <= out_slot_nxt;
    out_handle_r <= out_handle_nxt;
    out_hv_r     <= out_hv_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_handle_r, out_slot_r};
  assign out_tuser  = out_hv_r;

  // A slot read is always followed by the response state that collects it.
  a_read_then_resp: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |=> (state_r == ST_RESP))
    else $error("slot read not followed by response state");

  // The remainder unit only finishes while the controller waits for it.
  a_wrap_done_in_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    wrap_done |-> (state_r == ST_WRAP))
    else $error("wrap result arrived outside wrap state");

  // A new result is loaded only from the response state.
  a_out_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_RESP))
    else $error("output loaded without a slot read");

  // Frame writes outside the sweep only happen while recording is armed.
  a_write_armed: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && (state_r == ST_IDLE)) |-> (frames_left_r != '0))
    else $error("frame written while recording is off");

  // The record head never passes the memory depth.
  a_record_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    record_slot_r <= SLOT_W'(DEPTH))
    else $error("record head beyond memory depth");

endmodule

### rtl/core/lfs_slot_mem.sv
// Slot memory of the looping frame store: one write port, one registered read port.
// Depends on lfs_pkg for the entry width.
module lfs_slot_mem
  import lfs_pkg::*;
#(
  parameter int DEPTH = MAX_SLOTS_DEF,
  parameter int IDX_W = 8
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [IDX_W-1:0]   wr_addr,
  input  logic [SLOT_DW-1:0] wr_data,
  input  logic               rd_en,
  input  logic [IDX_W-1:0]   rd_addr,
  output logic [SLOT_DW-1:0] rd_data
);

  logic [SLOT_DW-1:0] mem [DEPTH];
  logic [SLOT_DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/core/lfs_wrap_unit.sv
// Bit-serial remainder unit: reduces a signed position modulo the loop length,
// one dividend bit per cycle, and wraps negative values into 0..len-1.
// Depends on lfs_pkg for the request type and position width.
module lfs_wrap_unit
  import lfs_pkg::*;
#(
  parameter int SLOT_W = 9
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lfs_wrap_req_t     req,
  input  logic [SLOT_W-1:0] len,
  output logic              done,
  output logic [SLOT_W-1:0] result
);

  localparam int CNT_W = $clog2(POS_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [POS_W-1:0]  mag_r, mag_nxt;
  logic              neg_r, neg_nxt;
  logic [SLOT_W-1:0] rem_r, rem_nxt;
  logic [SLOT_W:0]   trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    mag_nxt  = mag_r;
    neg_nxt  = neg_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, mag_r[POS_W-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      mag_nxt  = req.mag;
      neg_nxt  = req.neg;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // The partial remainder stays below len, so one compare and subtract suffices.
      if (trial >= {1'b0, len}) begin
        rem_nxt = SLOT_W'(trial - {1'b0, len});
      end else begin
        rem_nxt = SLOT_W'(trial);
      end
      mag_nxt = {mag_r[POS_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(POS_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    mag_r <= mag_nxt;
    neg_r <= neg_nxt;
    rem_r <= rem_nxt;
  end

  assign done   = done_r;
  assign result = (neg_r && (rem_r != '0)) ? (len - rem_r) : rem_r;

endmodule

### test/looping_frame_store_checker.sv
`timescale 1ns / 1ps
// Checker for the looping frame store: watches the request, result and configuration
// channels, predicts every played slot and compares it. Depends on lfs_pkg.
module looping_frame_store_checker
  import lfs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [47:0]          in_tdata,   // position, duration, frame_handle
  input  logic [OP_W-1:0]      in_tuser,   // opcode
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [23:0]          out_tdata,  // slot_index, played_handle
  input  logic [0:0]           out_tuser,  // handle_valid
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEN_W-1:0]     cfg_data,
  output int                   mismatches,
  output int                   pending
);

  typedef struct {
    logic [7:0]          slot;
    logic [HANDLE_W-1:0] handle;
    logic                full;
  } played_slot_t;

  played_slot_t expected_plays[$];
  played_slot_t got_play;

  logic                slot_full   [MAX_SLOTS_DEF];
  logic [HANDLE_W-1:0] slot_handle [MAX_SLOTS_DEF];
  int                  play_head;
  logic                played_past_end;
  int                  record_head;
  logic [15:0]         frames_to_record;
  logic [LEN_W-1:0]    loop_len;
  logic                loop_on;

  function automatic int slots_in_use();
    int l;
    l = loop_len;
    if (l < 2) l = 2;
    if (l > MAX_SLOTS_DEF) l = MAX_SLOTS_DEF;
    return l;
  endfunction

  // Signed position reduced into 0..len-1.
  function automatic int wrap_slot(logic signed [POS_W-1:0] p, int len);
    int v;
    v = p;
    v = v % len;
    if (v < 0) v += len;
    return v;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < 100) $display("%0t ns: %s got %0h, want %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic empty_slots();
    for (int i = 0; i < MAX_SLOTS_DEF; i++) begin
      slot_full[i]   = 1'b0;
      slot_handle[i] = '0;
    end
    play_head       = 0;
    played_past_end = 1'b0;
    record_head     = 0;
  endtask

  task automatic play_next_slot();
    int len, s;
    played_slot_t e;
    len = slots_in_use();
    if (!loop_on && played_past_end) return;
    s        = play_head % len;
    e.slot   = s[7:0];
    e.handle = slot_full[s] ? slot_handle[s] : '0;
    e.full   = slot_full[s];
    expected_plays.push_back(e);
    s++;
    if (s >= len) begin
      s = 0;
      played_past_end = 1'b1;
    end
    play_head = s;
  endtask

  task automatic apply_request(logic [OP_W-1:0] op, logic signed [POS_W-1:0] pos,
                               logic signed [DUR_W-1:0] dur, logic [HANDLE_W-1:0] handle);
    int len, d;
    len = slots_in_use();
    case (op)
      OP_FRAME_IN: begin
        if (frames_to_record != 0) begin
          if (record_head >= len) begin
            // The loop shrank under the record head: recording just stops.
            frames_to_record = '0;
          end else begin
            slot_full[record_head]   = 1'b1;
            slot_handle[record_head] = handle;
            frames_to_record--;
            record_head++;
            if (record_head == len) frames_to_record = '0;
          end
        end
      end
      OP_PLAY: play_next_slot();
      OP_SEEK, OP_SEEK_PLAY: begin
        play_head       = wrap_slot(pos, len);
        played_past_end = 1'b0;
        if (op == OP_SEEK_PLAY) play_next_slot();
      end
      OP_RECORD: begin
        record_head = wrap_slot(pos, len);
        d = dur;
        if (d <= 0) d = len - record_head;
        frames_to_record = d[15:0];
      end
      OP_STORE_ONE: begin
        record_head      = wrap_slot(pos, len);
        frames_to_record = 16'd1;
      end
      OP_STOP: frames_to_record = '0;
      default: empty_slots();  // clear keeps an armed recording count
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      empty_slots();
      frames_to_record = '0;
      loop_len         = LOOP_LENGTH_RST;
      loop_on          = 1'b1;
      expected_plays.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_LOOP_LENGTH) loop_len = cfg_data;
        else if (cfg_index == CFG_LOOP_ENABLE) loop_on = cfg_data[0];
      end
      if (out_tvalid && out_tready) begin
        if (expected_plays.size() == 0) begin
          report_mismatch("played slot with nothing pending", 32'(out_tdata), 32'd0);
        end else begin
          got_play = expected_plays.pop_front();
          if (out_tdata[7:0] !== got_play.slot)
            report_mismatch("slot_index", 32'(out_tdata[7:0]), 32'(got_play.slot));
          if (out_tdata[23:8] !== got_play.handle)
            report_mismatch("played_handle", 32'(out_tdata[23:8]), 32'(got_play.handle));
          if (out_tuser[0] !== got_play.full)
            report_mismatch("handle_valid", 32'(out_tuser[0]), 32'(got_play.full));
        end
      end
      if (in_tvalid && in_tready)
        apply_request(in_tuser, in_tdata[15:0], in_tdata[31:16], in_tdata[47:32]);
    end
    pending = expected_plays.size();
  end

endmodule

### test/looping_frame_store_tb.sv
`timescale 1ns / 1ps
// Testbench top for the looping frame store: clock, reset, request and configuration
// stimulus, receiver stalls and the verdict. Depends on lfs_pkg and the checker module.
module looping_frame_store_tb
  import lfs_pkg::*;
();

  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = 300;   // covers a clearing sweep plus the slowest request
  localparam int QUIET_LIMIT  = 5000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [47:0]          in_tdata;   // position, duration, frame_handle
  logic [OP_W-1:0]      in_tuser;   // opcode
  logic                 out_tvalid;
  logic                 out_tready;
  logic [23:0]          out_tdata;  // slot_index, played_handle
  logic [0:0]           out_tuser;  // handle_valid
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LEN_W-1:0]     cfg_data;
  int                   mismatches;
  int                   pending;

  bit idle_on  = 1'b1;
  bit stall_on = 1'b1;
  bit hold_req = 1'b0;
  int cur_len  = MAX_SLOTS_DEF;

  looping_frame_store dut (.*);
  looping_frame_store_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: random stalls, and one long hold-off when asked for.
  initial begin : receiver
    bit seen;
    seen = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != seen) begin
        seen = hold_req;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_tready <= !stall_on || ($urandom_range(99) >= 23);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_req(logic [OP_W-1:0] op, logic [15:0] pos, logic [15:0] dur,
                          logic [15:0] handle);
    while (idle_on && $urandom_range(99) < 23) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {handle, dur, pos};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_position(int len);
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'hffff;
      3, 4:    return 16'($urandom);
      5:       return 16'(0 - $urandom_range(len + 2));
      default: return 16'($urandom_range(len + 3));
    endcase
  endfunction

  function automatic logic [15:0] pick_duration();
    case ($urandom_range(7))
      0:       return 16'd0;
      1:       return 16'($urandom);
      2:       return 16'(0 - $urandom_range(5));
      default: return 16'($urandom_range(12, 1));
    endcase
  endfunction

  // Mostly well-formed sequences: arm a recording then feed frames, seek then play.
  task automatic run_phase(int n_items);
    int sent, k;
    logic [OP_W-1:0] op;
    sent = 0;
    while (sent < n_items) begin
      k = $urandom_range(12, 1);
      case ($urandom_range(9))
        0, 1, 2: begin
          send_req(OP_RECORD, pick_position(cur_len), pick_duration(), 16'($urandom));
          repeat (k) send_req(OP_FRAME_IN, 16'($urandom), 16'($urandom), 16'($urandom));
          sent += k + 1;
        end
        3: begin
          send_req(OP_STORE_ONE, pick_position(cur_len), 16'($urandom), 16'($urandom));
          send_req(OP_FRAME_IN, 16'($urandom), 16'($urandom), 16'($urandom));
          sent += 2;
        end
        4, 5, 6: begin
          op = $urandom_range(1) ? OP_SEEK : OP_SEEK_PLAY;
          send_req(op, pick_position(cur_len), 16'($urandom), 16'($urandom));
          repeat (k) send_req(OP_PLAY, 16'($urandom), 16'($urandom), 16'($urandom));
          sent += k + 1;
        end
        7: begin
          repeat (k) send_req(OP_PLAY, 16'($urandom), 16'($urandom), 16'($urandom));
          sent += k;
        end
        default: begin
          op = OP_W'($urandom_range(OP_CLEAR));
          send_req(op, pick_position(cur_len), pick_duration(), 16'($urandom));
          sent++;
        end
      endcase
    end
  endtask

  // Leaves both heads at the top of the current loop, so that a shorter loop
  // finds them beyond its end.
  task automatic change_setting(logic [LEN_W-1:0] len_reg, bit en);
    send_req(OP_SEEK, 16'(cur_len - 1), 16'($urandom), 16'($urandom));
    send_req(OP_RECORD, 16'(cur_len - 1), 16'd5, 16'($urandom));
    wait_idle();
    write_reg(CFG_LOOP_LENGTH, len_reg);
    write_reg(CFG_LOOP_ENABLE, {{(LEN_W-1){1'b0}}, en});
    cfg_valid <= 1'b0;
    cur_len = (len_reg < 2) ? 2 : (len_reg > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF : len_reg;
    send_req(OP_PLAY, 16'($urandom), 16'($urandom), 16'($urandom));
    send_req(OP_FRAME_IN, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  initial begin : stimulus
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= OP_FRAME_IN;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_LOOP_LENGTH;
    cfg_data  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests at the reset setting.
    send_req(OP_PLAY,      16'h0000, 16'h0000, 16'h0000);
    send_req(OP_FRAME_IN,  16'hffff, 16'hffff, 16'hffff);  // not recording: ignored
    send_req(OP_RECORD,    16'hffff, 16'h0000, 16'h0000);  // last slot up to the end
    send_req(OP_FRAME_IN,  16'h0000, 16'h0000, 16'hffff);
    send_req(OP_FRAME_IN,  16'h0000, 16'h0000, 16'h1234);  // count ran out: ignored
    send_req(OP_STORE_ONE, 16'h8000, 16'h0000, 16'h0000);
    send_req(OP_FRAME_IN,  16'h0000, 16'h0000, 16'h0000);
    send_req(OP_SEEK_PLAY, 16'h7fff, 16'h0000, 16'h0000);  // plays the last slot, wraps
    send_req(OP_PLAY,      16'h0000, 16'h0000, 16'h0000);
    send_req(OP_SEEK,      16'h8000, 16'h0000, 16'h0000);
    send_req(OP_RECORD,    16'h0001, 16'h7fff, 16'h0000);
    send_req(OP_FRAME_IN,  16'h0000, 16'h0000, 16'haaaa);
    send_req(OP_FRAME_IN,  16'h0000, 16'h0000, 16'h5555);
    send_req(OP_STOP,      16'h0000, 16'h0000, 16'h0000);
    send_req(OP_FRAME_IN,  16'h0000, 16'h0000, 16'h0f0f);
    send_req(OP_RECORD,    16'h0003, 16'h8000, 16'h0000);  // most negative duration
    send_req(OP_FRAME_IN,  16'h0000, 16'h0000, 16'h8001);
    repeat (4) send_req(OP_PLAY, 16'h0000, 16'h0000, 16'h0000);
    send_req(OP_CLEAR,     16'h0000, 16'h0000, 16'h0000);
    send_req(OP_FRAME_IN,  16'h0000, 16'h0000, 16'h7777);  // armed count survives a clear
    send_req(OP_PLAY,      16'h0000, 16'h0000, 16'h0000);
    send_req(OP_PLAY,      16'h0000, 16'h0000, 16'h0000);

    run_phase(180);
    change_setting(9'd2, 1'b0);
    run_phase(180);

    // Long receiver hold-off while plays keep coming, so the input backs up.
    change_setting(9'd17, 1'b1);
    hold_req = 1'b1;
    repeat (60) send_req(OP_PLAY, 16'($urandom), 16'($urandom), 16'($urandom));
    run_phase(120);

    change_setting(9'd0, 1'b1);
    run_phase(180);
    change_setting(9'd511, 1'b0);
    run_phase(180);
    change_setting(9'd1, 1'b1);
    run_phase(180);
    change_setting(9'd3, 1'b0);
    run_phase(180);

    // A stretch with no idling on either side.
    change_setting(9'd300, 1'b1);
    idle_on  = 1'b0;
    stall_on = 1'b0;
    run_phase(180);
    idle_on  = 1'b1;
    stall_on = 1'b1;

    change_setting(9'd128, 1'b0);
    run_phase(180);
    change_setting(9'($urandom_range(511)), 1'($urandom_range(1)));
    run_phase(180);

    wait_idle();
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
